// File: hdl/four_lane_xorshift_uniform_floats_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-lane xorshift uniform float unit
// Shared property wrappers on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef FOUR_LANE_XORSHIFT_UNIFORM_FLOATS_UNIT_ASSERT_SVH
`define FOUR_LANE_XORSHIFT_UNIFORM_FLOATS_UNIT_ASSERT_SVH

// same-cycle implication
`define FLXUF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FLXUF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/flxuf_pkg.sv
// ----------------------------------------------------------------------------
// flxuf_pkg
// Types, constants and helper functions of the four-lane xorshift128+ unit.
// ----------------------------------------------------------------------------
package flxuf_pkg;

	localparam int LANES     = 4;
	localparam int WORD_W    = 64;
	localparam int UNI_W     = 30;
	localparam int KEPT_BITS = 24;
	localparam int CFG_IDX_W = 4;

	localparam int SHIFT_A = 23;
	localparam int SHIFT_B = 18;
	localparam int SHIFT_C = 5;

	localparam logic [UNI_W-1:0] FLOAT_ONE = UNI_W'(32'h3F80_0000);

	// register map: first words at 0..3, second words at 4..7
	localparam int CFG_SEED_FIRST_BASE  = 0;
	localparam int CFG_SEED_SECOND_BASE = LANES;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [UNI_W-1:0]  uni_t;

	typedef struct packed {
		logic load_first;
		logic load_second;
		logic advance;
	} lane_ctl_t;

	function automatic word_t nonzero(input word_t v);
		return (v == '0) ? word_t'(1) : v;
	endfunction

	// one xorshift step: returns the new second word
	function automatic word_t xs_step(input word_t a, input word_t b);
		word_t t;
		t = a ^ (a << SHIFT_A);
		t = t ^ (t >> SHIFT_B);
		return t ^ b ^ (b >> SHIFT_C);
	endfunction

	function automatic uni_t to_float(input word_t v);
		return uni_t'(v[WORD_W-1 -: KEPT_BITS]) | FLOAT_ONE;
	endfunction

endpackage

// File: hdl/flxuf_lane.sv
// ----------------------------------------------------------------------------
// flxuf_lane
// One xorshift128+ lane: two state words, two advances per request.
// ----------------------------------------------------------------------------
module flxuf_lane
	import flxuf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  lane_ctl_t ctl,
	input  word_t     seed,
	output uni_t      uni_first,
	output uni_t      uni_second
);

	word_t first_q;
	word_t second_q;
	word_t next1;
	word_t next2;

	// second advance starts from (old second, next1)
	always_comb begin
		next1      = xs_step(first_q, second_q);
		next2      = xs_step(second_q, next1);
		uni_first  = to_float(next1 + second_q);
		uni_second = to_float(next2 + next1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= word_t'(1);
			second_q <= word_t'(1);
		end else if (ctl.load_first || ctl.load_second) begin
			if (ctl.load_first) begin
				first_q <= nonzero(seed);
			end
			if (ctl.load_second) begin
				second_q <= nonzero(seed);
			end
		end else if (ctl.advance) begin
			first_q  <= next1;
			second_q <= next2;
		end
	end

endmodule

// File: hdl/four_lane_xorshift_uniform_floats_unit.sv
// ----------------------------------------------------------------------------
// four_lane_xorshift_uniform_floats_unit
// Four xorshift128+ lanes; each request yields eight float bit patterns in
// [1,2). One request is accepted every cycle: the lane state updates and the
// result register loads at the same edge, so a result appears in the cycle
// after its request. Throughput is one request per cycle, limited only by
// downstream stall. Seeds are written through the cfg port (index 0..3 first
// words, 4..7 second words, zero loads as one, indexes above 7 are ignored)
// and take effect at once; every state word resets to one.
// ----------------------------------------------------------------------------
module four_lane_xorshift_uniform_floats_unit
	import flxuf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 request,

	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [UNI_W-1:0]     uniform_0,
	output logic [UNI_W-1:0]     uniform_1,
	output logic [UNI_W-1:0]     uniform_2,
	output logic [UNI_W-1:0]     uniform_3,
	output logic [UNI_W-1:0]     uniform_4,
	output logic [UNI_W-1:0]     uniform_5,
	output logic [UNI_W-1:0]     uniform_6,
	output logic [UNI_W-1:0]     uniform_7,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	logic      req_acc;
	logic      fire;
	logic      res_valid_q;
	lane_ctl_t lane_ctl [LANES];
	uni_t      uni_first [LANES];
	uni_t      uni_second [LANES];
	uni_t      uni_q [2*LANES];

	assign cfg_ready = 1'b1;
	assign req_stall = res_valid_q && res_stall;
	assign req_acc   = req_valid && !req_stall;
	assign fire      = req_acc && request;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		always_comb begin
			lane_ctl[l].load_first  = cfg_valid &&
				(cfg_index == CFG_IDX_W'(CFG_SEED_FIRST_BASE + l));
			lane_ctl[l].load_second = cfg_valid &&
				(cfg_index == CFG_IDX_W'(CFG_SEED_SECOND_BASE + l));
			lane_ctl[l].advance     = fire;
		end

		flxuf_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (lane_ctl[l]),
			.seed       (cfg_data),
			.uni_first  (uni_first[l]),
			.uni_second (uni_second[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req_acc) begin
			res_valid_q <= request;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < LANES; i++) begin
				uni_q[i]         <= uni_first[i];
				uni_q[i + LANES] <= uni_second[i];
			end
		end
	end

	assign res_valid = res_valid_q;
	assign uniform_0 = uni_q[0];
	assign uniform_1 = uni_q[1];
	assign uniform_2 = uni_q[2];
	assign uniform_3 = uni_q[3];
	assign uniform_4 = uni_q[4];
	assign uniform_5 = uni_q[5];
	assign uniform_6 = uni_q[6];
	assign uniform_7 = uni_q[7];

endmodule

// File: hdl/flxuf_checker.sv
// ----------------------------------------------------------------------------
// flxuf_checker
// Port-level checks of the uniform float unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "four_lane_xorshift_uniform_floats_unit_assert.svh"

module flxuf_checker
	import flxuf_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input logic             request,
	input logic             res_valid,
	input logic             res_stall,
	input logic [UNI_W-1:0] uniform_0,
	input logic [UNI_W-1:0] uniform_7
);

	// a stalled result holds
	`FLXUF_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(uniform_0), "stalled result changed")

	// the request side only backs up when the result register is full and stalled
	`FLXUF_ASSERT_NOW(a_stall_cause, req_stall, res_valid && res_stall, "request stalled without a waiting result")

	// every taken request yields a result next cycle
	`FLXUF_ASSERT_NEXT(a_req_to_res, req_valid && !req_stall && request, res_valid, "request produced no result")

	// a delivered result leaves nothing behind unless a new request came in
	`FLXUF_ASSERT_NEXT(a_no_extra, res_valid && !res_stall && !(req_valid && !req_stall && request), !res_valid, "result repeated")

	// exponent field always encodes [1,2)
	`FLXUF_ASSERT_NOW(a_float_range, res_valid, (uniform_0[UNI_W-1 -: 7] == 7'h7F) && (uniform_7[UNI_W-1 -: 7] == 7'h7F), "float out of [1,2)")

endmodule

bind four_lane_xorshift_uniform_floats_unit flxuf_checker u_flxuf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.request   (request),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.uniform_0 (uniform_0),
	.uniform_7 (uniform_7)
);

// File: sim/tb_four_lane_xorshift_uniform_floats_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench of the four-lane xorshift128+ uniform float unit
// A table of directed requests and seed writes runs first. Phases of random
// requests follow, with the seeds reprogrammed between phases. A local
// predictor of the four lanes works out each batch of eight floats, and every
// result taken from the unit is checked against the oldest batch due.
// ----------------------------------------------------------------------------
module tb_four_lane_xorshift_uniform_floats_unit;
	import flxuf_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 64;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int PHASES        = 7;
	localparam int PHASE_ITEMS   = 170;
	localparam int HOLD_PHASE    = 2;
	localparam int PRINT_CAP     = 50;
	localparam int N_DIRECTED    = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_UNUSED = CFG_IDX_W'(2 * LANES);
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST         = '1;

	typedef logic [2*LANES-1:0][UNI_W-1:0] batch_t;

	typedef enum logic [1:0] {ROW_REQ, ROW_SEED, ROW_SEED_ALL} row_kind_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD}
		stall_mode_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		word_t                data;
		logic                 req;
		bit                   pinned;
		uni_t                 value;
	} row_t;

	typedef struct {
		bit   pinned;
		uni_t value;
	} pinned_t;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	logic                 request;
	logic                 res_valid;
	logic                 res_stall;
	logic [UNI_W-1:0]     uniform_0, uniform_1, uniform_2, uniform_3;
	logic [UNI_W-1:0]     uniform_4, uniform_5, uniform_6, uniform_7;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	word_t   lane_first_w  [LANES];
	word_t   lane_second_w [LANES];
	batch_t  float_batches_due [$];
	pinned_t pinned_q [$];
	int      fault_count;
	bit      hold_off_wanted;

	// with every state word at one, both advances of every lane give 0x3F800000
	row_t directed_rows [N_DIRECTED] = '{
		'{ROW_REQ,      '0,                   '0,                    1'b1, 1'b1, FLOAT_ONE},
		'{ROW_REQ,      '0,                   '0,                    1'b0, 1'b0, '0},
		'{ROW_REQ,      '0,                   '0,                    1'b1, 1'b0, '0},
		'{ROW_SEED_ALL, '0,                   '0,                    1'b0, 1'b0, '0},
		'{ROW_REQ,      '0,                   '0,                    1'b1, 1'b1, FLOAT_ONE},
		'{ROW_SEED,     CFG_IDX_FIRST_UNUSED, '1,                    1'b0, 1'b0, '0},
		'{ROW_SEED,     CFG_IDX_LAST,         '1,                    1'b0, 1'b0, '0},
		'{ROW_REQ,      '0,                   '0,                    1'b1, 1'b0, '0},
		'{ROW_SEED_ALL, '0,                   '1,                    1'b0, 1'b0, '0},
		'{ROW_REQ,      '0,                   '0,                    1'b1, 1'b0, '0},
		'{ROW_REQ,      '0,                   '0,                    1'b1, 1'b0, '0},
		'{ROW_SEED,     CFG_IDX_W'(CFG_SEED_FIRST_BASE), 64'h8000_0000_0000_0000,
			1'b0, 1'b0, '0},
		'{ROW_SEED,     CFG_IDX_W'(CFG_SEED_SECOND_BASE + LANES - 1), 64'h0123_4567_89AB_CDEF,
			1'b0, 1'b0, '0},
		'{ROW_REQ,      '0,                   '0,                    1'b1, 1'b0, '0},
		'{ROW_REQ,      '0,                   '0,                    1'b0, 1'b0, '0},
		'{ROW_REQ,      '0,                   '0,                    1'b1, 1'b0, '0}
	};

	four_lane_xorshift_uniform_floats_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.request   (request),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.uniform_0 (uniform_0),
		.uniform_1 (uniform_1),
		.uniform_2 (uniform_2),
		.uniform_3 (uniform_3),
		.uniform_4 (uniform_4),
		.uniform_5 (uniform_5),
		.uniform_6 (uniform_6),
		.uniform_7 (uniform_7),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb_four_lane_xorshift_uniform_floats_unit NOT OK");
		$finish;
	end

	task automatic report_fault(input string msg);
		if (fault_count < PRINT_CAP)
			$display("ERROR @%0t: %s", $time, msg);
		fault_count++;
	endtask

	// ---- predictor ----------------------------------------------------------

	function automatic word_t seed_to_word(input word_t v);
		return (v == '0) ? word_t'(1) : v;
	endfunction

	function automatic uni_t step_lane(input int lane);
		word_t a, b, sum;
		a = lane_first_w[lane];
		b = lane_second_w[lane];
		a = a ^ (a << 23);
		a = a ^ (a >> 18);
		a = a ^ b ^ (b >> 5);
		lane_first_w[lane]  = b;
		lane_second_w[lane] = a;
		sum = a + b;
		// top 24 bits under the exponent of 1.0
		return uni_t'(sum >> (WORD_W - 24)) | FLOAT_ONE;
	endfunction

	function automatic batch_t draw_batch();
		batch_t b;
		for (int l = 0; l < LANES; l++)
			b[l] = step_lane(l);
		for (int l = 0; l < LANES; l++)
			b[l + LANES] = step_lane(l);
		return b;
	endfunction

	function automatic void load_seed(input logic [CFG_IDX_W-1:0] idx, input word_t v);
		if (idx < CFG_SEED_SECOND_BASE)
			lane_first_w[idx - CFG_SEED_FIRST_BASE] = seed_to_word(v);
		else if (idx < CFG_IDX_FIRST_UNUSED)
			lane_second_w[idx - CFG_SEED_SECOND_BASE] = seed_to_word(v);
	endfunction

	// ---- observation: config, requests and results in one place -------------

	always @(posedge clk) begin : observe
		pinned_t pin;
		batch_t  want, got;
		if (!arst_n) begin
			for (int l = 0; l < LANES; l++) begin
				lane_first_w[l]  = word_t'(1);
				lane_second_w[l] = word_t'(1);
			end
		end else begin
			if (cfg_valid && cfg_ready)
				load_seed(cfg_index, cfg_data);
			if (req_valid && !req_stall) begin
				pin = '{pinned: 1'b0, value: '0};
				if (pinned_q.size() != 0)
					pin = pinned_q.pop_front();
				if (request === 1'b1) begin
					want = draw_batch();
					if (pin.pinned)
						want = {2*LANES{pin.value}};
					float_batches_due.push_back(want);
				end
			end
			if (res_valid && !res_stall) begin
				got = {uniform_7, uniform_6, uniform_5, uniform_4,
					uniform_3, uniform_2, uniform_1, uniform_0};
				if (float_batches_due.size() == 0) begin
					report_fault($sformatf("result %h with no request outstanding", got));
				end else begin
					want = float_batches_due.pop_front();
					for (int k = 0; k < 2 * LANES; k++)
						if (got[k] !== want[k])
							report_fault($sformatf("uniform_%0d got %h expected %h",
								k, got[k], want[k]));
				end
			end
		end
	end

	// ---- result side stall pattern ------------------------------------------

	initial begin : result_side
		stall_mode_t mode;
		int          span_left;
		int          hold_left;
		mode      = STALL_NONE;
		span_left = 0;
		hold_left = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (span_left == 0) begin
				mode      = stall_mode_t'($urandom_range(0, 3));
				span_left = $urandom_range(10, 150);
			end
			span_left--;
			if (hold_left != 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (hold_off_wanted) begin
				hold_off_wanted = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				res_stall <= 1'b1;
			end else begin
				case (mode)
					STALL_NONE:    res_stall <= 1'b0;
					STALL_LIGHT:   res_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY:   res_stall <= ($urandom_range(0, 3) != 0);
					default:       res_stall <= (span_left % 3 == 0);
				endcase
			end
		end
	end

	// ---- request side and seed port -----------------------------------------

	task automatic send_request(input logic bit_val, input bit pinned, input uni_t value);
		pinned_q.push_back('{pinned: pinned, value: value});
		req_valid <= 1'b1;
		request   <= bit_val;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// stop requests and let every due batch come out
	task automatic quiesce();
		req_valid <= 1'b0;
		@(posedge clk);
		while (float_batches_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [CFG_IDX_W-1:0] idx, input word_t v);
		quiesce();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic word_t pick_seed();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return word_t'(1);
			3:       return 64'h8000_0000_0000_0000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin : stimulus
		int   sent;
		int   burst;
		int   waited;
		logic r;
		fault_count     = 0;
		hold_off_wanted = 1'b0;
		arst_n     = 1'b0;
		req_valid <= 1'b0;
		request   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			case (directed_rows[i].kind)
				ROW_REQ:
					send_request(directed_rows[i].req, directed_rows[i].pinned,
						directed_rows[i].value);
				ROW_SEED:
					write_seed(directed_rows[i].idx, directed_rows[i].data);
				default:
					for (int s = 0; s < 2 * LANES; s++)
						write_seed(CFG_IDX_W'(s), directed_rows[i].data);
			endcase
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == PHASES - 1) begin
				for (int s = 0; s < 2 * LANES; s++)
					write_seed(CFG_IDX_W'(s), '1);
			end else if (phase > 0) begin
				for (int s = 0; s < 2 * LANES; s++)
					if ($urandom_range(0, 1) == 1)
						write_seed(CFG_IDX_W'(s), pick_seed());
				if ($urandom_range(0, 2) == 0)
					write_seed(CFG_IDX_W'($urandom_range(CFG_IDX_FIRST_UNUSED, CFG_IDX_LAST)),
						pick_seed());
			end
			sent = 0;
			if (phase == HOLD_PHASE) begin
				// result side holds off while requests keep coming
				hold_off_wanted = 1'b1;
				repeat (40) send_request(1'b1, 1'b0, '0);
				sent += 40;
				quiesce();
			end
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 40);
				repeat (burst) begin
					r = ($urandom_range(0, 9) != 0);
					send_request(r, 1'b0, '0);
					if (r)
						sent++;
				end
				if ($urandom_range(0, 15) == 0) begin
					quiesce();
				end else if ($urandom_range(0, 3) != 0) begin
					req_valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
		end

		req_valid <= 1'b0;
		waited = 0;
		while (float_batches_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (float_batches_due.size() != 0)
			report_fault($sformatf("%0d batches never came out", float_batches_due.size()));
		repeat (SETTLE_CYCLES * 4) @(posedge clk);

		if (fault_count == 0)
			$display("tb_four_lane_xorshift_uniform_floats_unit OK");
		else
			$display("tb_four_lane_xorshift_uniform_floats_unit NOT OK");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/flxuf_pkg.sv
hdl/flxuf_lane.sv
hdl/four_lane_xorshift_uniform_floats_unit.sv
hdl/flxuf_checker.sv
sim/tb_four_lane_xorshift_uniform_floats_unit.sv
